[rtl/capm_pkg.sv]
// Shared constants, command and status types, and helper functions for the attitude controller.
package capm_pkg;

	localparam int unsigned MOTOR_MIN = 1000;
	localparam int unsigned MOTOR_MAX = 2000;

	localparam logic [10:0] CUT_THROTTLE = 11'd1050;
	localparam logic signed [31:0] TILT_LIMIT = 32'sd4259840;
	localparam logic [13:0] DIV_SCALE = 14'd15625;
	localparam logic signed [39:0] INT40_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic [47:0] SUM_LIMIT = 48'h8000_0000_0000;

	localparam logic signed [34:0] MOTOR_LO = 35'(MOTOR_MIN * 65536);
	localparam logic signed [34:0] MOTOR_HI = 35'(MOTOR_MAX * 65536);
	localparam logic [11:0] MOTOR_CUT = 12'(MOTOR_MIN);

	localparam int unsigned DIV_ITER = 33;

	localparam logic [2:0] REG_ANGLE_GAIN = 3'd0;
	localparam logic [2:0] REG_RATE_GAIN  = 3'd1;
	localparam logic [2:0] REG_RATE_TI    = 3'd2;
	localparam logic [2:0] REG_RATE_TD    = 3'd3;
	localparam logic [2:0] REG_YAW_GAIN   = 3'd4;
	localparam logic [2:0] REG_YAW_TD     = 3'd5;
	localparam logic [2:0] REG_INT_LIMIT  = 3'd6;
	localparam logic [2:0] REG_OUT_LIMIT  = 3'd7;

	localparam logic [3:0] OP_NONE      = 4'd0;
	localparam logic [3:0] OP_MUL_TI    = 4'd1;
	localparam logic [3:0] OP_SAVE_DINT = 4'd2;
	localparam logic [3:0] OP_DIFF      = 4'd3;
	localparam logic [3:0] OP_ERR       = 4'd4;
	localparam logic [3:0] OP_INTEG     = 4'd5;
	localparam logic [3:0] OP_MUL_IP    = 4'd6;
	localparam logic [3:0] OP_DIV_I     = 4'd7;
	localparam logic [3:0] OP_ACC       = 4'd8;
	localparam logic [3:0] OP_MUL_DT    = 4'd9;
	localparam logic [3:0] OP_MUL_K     = 4'd10;
	localparam logic [3:0] OP_DIV_D     = 4'd11;
	localparam logic [3:0] OP_MUL_G     = 4'd12;
	localparam logic [3:0] OP_FIN       = 4'd13;
	localparam logic [3:0] OP_MIX       = 4'd14;

	localparam logic [1:0] AXIS_ROLL  = 2'd0;
	localparam logic [1:0] AXIS_PITCH = 2'd1;
	localparam logic [1:0] AXIS_YAW   = 2'd2;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] axis;
	} capm_cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic div_busy;
		logic out_free;
	} capm_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [11:0] motor_clamp(input logic signed [34:0] v);
		logic signed [34:0] c;
		c = v;
		if (v < MOTOR_LO) c = MOTOR_LO;
		else if (v > MOTOR_HI) c = MOTOR_HI;
		return c[27:16];
	endfunction

endpackage

[rtl/capm_mul.sv]
// Multicycle 60 by 24 bit unsigned multiplier built from three 20 by 24 bit partial products.
module capm_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [59:0] a,
	input  logic [23:0] b,
	output logic        busy,
	output logic [83:0] prod
);
	import capm_pkg::*;

	logic [59:0] a_q;
	logic [23:0] b_q;
	logic [43:0] pp_q;
	logic [83:0] acc_q;
	logic [1:0]  st_q;
	logic        busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			st_q   <= 2'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			st_q   <= 2'd0;
		end else if (busy_q) begin
			st_q <= st_q + 2'd1;
			if (st_q == 2'd3) busy_q <= 1'b0;
		end
	end

	// Chunks are taken high first, so the accumulator shifts by a fixed amount.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			pp_q <= {24'd0, a_q[59:40]} * {20'd0, b_q};
			a_q  <= {a_q[39:0], 20'd0};
			if (st_q != 2'd0) acc_q <= {acc_q[63:0], 20'd0} + {40'd0, pp_q};
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;
endmodule

[rtl/capm_div.sv]
// Restoring radix-4 divider for a 66-bit dividend and a 38-bit divisor.
module capm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [65:0] dividend,
	input  logic [37:0] divisor,
	output logic        busy,
	output logic [65:0] quot
);
	import capm_pkg::*;

	logic [65:0] quo_q, quo_nx;
	logic [37:0] rem_q, rem_nx, den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;

	always_comb begin
		logic [38:0] t;
		logic [37:0] r;
		logic [65:0] q;
		r = rem_q;
		q = quo_q;
		for (int i = 0; i < 2; i++) begin
			t = {r, q[65]};
			q = {q[64:0], 1'b0};
			if (t >= {1'b0, den_q}) begin
				t = t - {1'b0, den_q};
				q[0] = 1'b1;
			end
			r = t[37:0];
		end
		rem_nx = r;
		quo_nx = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(DIV_ITER - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
endmodule

[rtl/capm_dp.sv]
// Datapath: configuration registers, loop state, working registers, shared units and mixer.
module capm_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  capm_pkg::capm_cmd_t  cmd,
	output capm_pkg::capm_sts_t  sts,
	input  logic                 load,
	input  logic [10:0]          throttle_pwm,
	input  logic signed [31:0]   target_roll,
	input  logic signed [31:0]   target_pitch,
	input  logic signed [31:0]   target_yaw_rate,
	input  logic signed [31:0]   measured_roll,
	input  logic signed [31:0]   measured_pitch,
	input  logic signed [31:0]   rate_roll_axis,
	input  logic signed [31:0]   rate_pitch_axis,
	input  logic signed [31:0]   rate_yaw_axis,
	input  logic [15:0]          period_us,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [30:0]          cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [11:0]          motor_front_a,
	output logic [11:0]          motor_front_b,
	output logic [11:0]          motor_rear_a,
	output logic [11:0]          motor_rear_b,
	output logic                 cut_off
);
	import capm_pkg::*;

	logic [23:0] angle_gain_q, rate_gain_q, rate_ti_q, rate_td_q, yaw_gain_q, yaw_td_q;
	logic [30:0] int_lim_q, out_lim_q;

	logic [10:0]        thr_q;
	logic signed [31:0] tgt_q [0:2];
	logic signed [31:0] meas_q [0:1];
	logic signed [31:0] rate_q [0:2];
	logic [15:0]        per_q;

	logic signed [39:0] integ_q [0:1];
	logic signed [31:0] last_q [0:2];
	logic signed [31:0] lout_q [0:2];

	logic signed [31:0] e_q;
	logic signed [32:0] de_q;
	logic signed [63:0] sum_q;
	logic               sgn_q;
	logic [37:0]        dint_q;

	logic        out_valid_q, cut_q;
	logic [11:0] m0_q, m1_q, m2_q, m3_q;

	logic        mul_start, mul_busy, div_start, div_busy;
	logic [59:0] mul_a;
	logic [23:0] mul_b;
	logic [83:0] prod;
	logic [65:0] div_n, quot;
	logic [37:0] div_d;

	logic [1:0]         ax;
	logic               ai;
	logic signed [32:0] diff;
	logic [32:0]        diff_mag;
	logic [40:0]        rt_mag;
	logic signed [41:0] rt_s;
	logic signed [31:0] rt, e_c;
	logic signed [39:0] integ, lim40, inew;
	logic signed [40:0] isum;
	logic               add;
	logic [39:0]        imag;
	logic [32:0]        de_mag;
	logic [63:0]        smag;
	logic [47:0]        smag_s;
	logic signed [63:0] qs;
	logic [55:0]        fmag;
	logic [30:0]        fclamp;
	logic signed [31:0] fout;
	logic [23:0]        ti_eff;
	logic signed [34:0] thr35, r35, p35, y35;
	logic               cut_c;

	assign ax = cmd.axis;
	assign ai = cmd.axis[0];

	always_comb begin
		diff     = 33'(tgt_q[ax]) - 33'(meas_q[ai]);
		diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
		rt_mag   = prod[56:16];
		rt_s     = sgn_q ? -$signed({1'b0, rt_mag}) : $signed({1'b0, rt_mag});
		rt       = sat32(64'(rt_s));
		if (ax == AXIS_YAW) e_c = sat32(64'(tgt_q[AXIS_YAW]) - 64'(rate_q[AXIS_YAW]));
		else e_c = sat32(64'(rt) - 64'(rate_q[ax]));

		integ = integ_q[ai];
		lim40 = $signed({9'd0, int_lim_q});
		if (integ > lim40) add = (e_q < 0);
		else if (integ < -lim40) add = (e_q > 0);
		else add = 1'b1;
		isum = 41'(integ) + 41'(e_q);
		if (isum > 41'(INT40_MAX)) inew = INT40_MAX;
		else if (isum < -41'(INT40_MAX)) inew = -INT40_MAX;
		else inew = isum[39:0];

		imag   = integ[39] ? 40'(-integ) : 40'(integ);
		de_mag = de_q[32] ? 33'(-de_q) : 33'(de_q);
		smag   = sum_q[63] ? 64'(-sum_q) : 64'(sum_q);
		smag_s = (smag > {16'd0, SUM_LIMIT}) ? SUM_LIMIT : smag[47:0];
		qs     = $signed({1'b0, quot[62:0]});
		fmag   = prod[71:16];
		fclamp = (fmag > {25'd0, out_lim_q}) ? out_lim_q : fmag[30:0];
		fout   = sgn_q ? -$signed({1'b0, fclamp}) : $signed({1'b0, fclamp});
		ti_eff = (rate_ti_q == 24'd0) ? 24'd1 : rate_ti_q;
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_n     = {prod[55:0], 10'd0};
		div_d     = dint_q;
		case (cmd.op)
			OP_MUL_TI: begin
				mul_start = 1'b1;
				mul_a     = {46'd0, DIV_SCALE};
				mul_b     = ti_eff;
			end
			OP_DIFF: begin
				mul_start = 1'b1;
				mul_a     = {27'd0, diff_mag};
				mul_b     = angle_gain_q;
			end
			OP_MUL_IP: begin
				mul_start = 1'b1;
				mul_a     = {20'd0, imag};
				mul_b     = {8'd0, per_q};
			end
			OP_MUL_DT: begin
				mul_start = 1'b1;
				mul_a     = {27'd0, de_mag};
				mul_b     = (ax == AXIS_YAW) ? yaw_td_q : rate_td_q;
			end
			OP_MUL_K: begin
				mul_start = 1'b1;
				mul_a     = prod[59:0];
				mul_b     = {10'd0, DIV_SCALE};
			end
			OP_MUL_G: begin
				mul_start = 1'b1;
				mul_a     = {12'd0, smag_s};
				mul_b     = (ax == AXIS_YAW) ? yaw_gain_q : rate_gain_q;
			end
			OP_DIV_I: begin
				div_start = 1'b1;
			end
			OP_DIV_D: begin
				div_start = 1'b1;
				div_n     = prod[75:10];
				div_d     = {22'd0, per_q};
			end
			default: begin
			end
		endcase
	end

	capm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (prod)
	);

	capm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.busy     (div_busy),
		.quot     (quot)
	);

	always_comb begin
		thr35 = $signed({8'd0, thr_q, 16'd0});
		r35   = 35'(lout_q[AXIS_ROLL]);
		p35   = 35'(lout_q[AXIS_PITCH]);
		y35   = 35'(lout_q[AXIS_YAW]);
		cut_c = (thr_q <= CUT_THROTTLE)
			|| (meas_q[0] >= TILT_LIMIT) || (meas_q[0] <= -TILT_LIMIT)
			|| (meas_q[1] >= TILT_LIMIT) || (meas_q[1] <= -TILT_LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_gain_q <= 24'd288358;
			rate_gain_q  <= 24'd170394;
			rate_ti_q    <= 24'd32768;
			rate_td_q    <= 24'd5243;
			yaw_gain_q   <= 24'd170394;
			yaw_td_q     <= 24'd5243;
			int_lim_q    <= 31'd6553600;
			out_lim_q    <= 31'd19660800;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANGLE_GAIN: angle_gain_q <= cfg_data[23:0];
				REG_RATE_GAIN:  rate_gain_q  <= cfg_data[23:0];
				REG_RATE_TI:    rate_ti_q    <= cfg_data[23:0];
				REG_RATE_TD:    rate_td_q    <= cfg_data[23:0];
				REG_YAW_GAIN:   yaw_gain_q   <= cfg_data[23:0];
				REG_YAW_TD:     yaw_td_q     <= cfg_data[23:0];
				REG_INT_LIMIT:  int_lim_q    <= cfg_data;
				REG_OUT_LIMIT:  out_lim_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q[0] <= '0;
			integ_q[1] <= '0;
			last_q[0]  <= '0;
			last_q[1]  <= '0;
			last_q[2]  <= '0;
		end else if (cmd.op == OP_INTEG) begin
			if (ax != AXIS_YAW && add) integ_q[ai] <= inew;
			last_q[ax] <= e_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_MIX) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			thr_q     <= throttle_pwm;
			tgt_q[0]  <= target_roll;
			tgt_q[1]  <= target_pitch;
			tgt_q[2]  <= target_yaw_rate;
			meas_q[0] <= measured_roll;
			meas_q[1] <= measured_pitch;
			rate_q[0] <= rate_roll_axis;
			rate_q[1] <= rate_pitch_axis;
			rate_q[2] <= rate_yaw_axis;
			per_q     <= (period_us == 16'd0) ? 16'd1 : period_us;
		end
		case (cmd.op)
			OP_SAVE_DINT: dint_q <= prod[37:0];
			OP_DIFF:      sgn_q <= diff[32];
			OP_ERR: begin
				e_q   <= e_c;
				de_q  <= 33'(e_c) - 33'(last_q[ax]);
				sum_q <= 64'(e_c);
			end
			OP_MUL_IP:    sgn_q <= integ[39];
			OP_MUL_DT:    sgn_q <= de_q[32];
			OP_MUL_G:     sgn_q <= sum_q[63];
			OP_ACC:       sum_q <= sum_q + (sgn_q ? -qs : qs);
			OP_FIN:       lout_q[ax] <= fout;
			OP_MIX: begin
				cut_q <= cut_c;
				if (cut_c) begin
					m0_q <= MOTOR_CUT;
					m1_q <= MOTOR_CUT;
					m2_q <= MOTOR_CUT;
					m3_q <= MOTOR_CUT;
				end else begin
					m0_q <= motor_clamp(thr35 - p35 + r35 - y35);
					m1_q <= motor_clamp(thr35 - p35 - r35 + y35);
					m2_q <= motor_clamp(thr35 + p35 + r35 + y35);
					m3_q <= motor_clamp(thr35 + p35 - r35 - y35);
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.mul_busy = mul_busy;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign motor_front_a = m0_q;
	assign motor_front_b = m1_q;
	assign motor_rear_a  = m2_q;
	assign motor_rear_b  = m3_q;
	assign cut_off       = cut_q;
endmodule

[rtl/capm_ctrl.sv]
// Controller: sequences the per-tick operations of the datapath and holds the input handshake.
module capm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_take,
	output logic                 in_ready,
	output capm_pkg::capm_cmd_t  cmd,
	input  capm_pkg::capm_sts_t  sts
);
	import capm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_MIX  = 2'd3;

	localparam logic [5:0] PC_ROLL  = 6'd2;
	localparam logic [5:0] PC_PITCH = 6'd14;
	localparam logic [5:0] PC_YAW   = 6'd26;
	localparam logic [5:0] PC_LAST  = 6'd33;

	logic [1:0] state_q;
	logic [5:0] pc_q;
	logic [3:0] slot;
	capm_cmd_t  prog;
	logic       units_idle;

	assign units_idle = !sts.mul_busy && !sts.div_busy;

	always_comb begin
		prog.op   = OP_NONE;
		prog.axis = AXIS_ROLL;
		slot      = 4'd0;
		if (pc_q == 6'd0) begin
			prog.op = OP_MUL_TI;
		end else if (pc_q < PC_ROLL) begin
			prog.op = OP_SAVE_DINT;
		end else if (pc_q < PC_YAW) begin
			prog.axis = (pc_q < PC_PITCH) ? AXIS_ROLL : AXIS_PITCH;
			slot      = (pc_q < PC_PITCH) ? 4'(pc_q - PC_ROLL) : 4'(pc_q - PC_PITCH);
			case (slot)
				4'd0:    prog.op = OP_DIFF;
				4'd1:    prog.op = OP_ERR;
				4'd2:    prog.op = OP_INTEG;
				4'd3:    prog.op = OP_MUL_IP;
				4'd4:    prog.op = OP_DIV_I;
				4'd5:    prog.op = OP_ACC;
				4'd6:    prog.op = OP_MUL_DT;
				4'd7:    prog.op = OP_MUL_K;
				4'd8:    prog.op = OP_DIV_D;
				4'd9:    prog.op = OP_ACC;
				4'd10:   prog.op = OP_MUL_G;
				4'd11:   prog.op = OP_FIN;
				default: prog.op = OP_NONE;
			endcase
		end else begin
			prog.axis = AXIS_YAW;
			slot      = 4'(pc_q - PC_YAW);
			case (slot)
				4'd0:    prog.op = OP_ERR;
				4'd1:    prog.op = OP_INTEG;
				4'd2:    prog.op = OP_MUL_DT;
				4'd3:    prog.op = OP_MUL_K;
				4'd4:    prog.op = OP_DIV_D;
				4'd5:    prog.op = OP_ACC;
				4'd6:    prog.op = OP_MUL_G;
				4'd7:    prog.op = OP_FIN;
				default: prog.op = OP_NONE;
			endcase
		end
	end

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.axis = AXIS_ROLL;
		case (state_q)
			ST_RUN: cmd = prog;
			ST_MIX: begin
				if (sts.out_free) cmd.op = OP_MIX;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= 6'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_RUN;
						pc_q    <= 6'd0;
					end
				end
				ST_RUN: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (units_idle) begin
						if (pc_q == PC_LAST) begin
							state_q <= ST_MIX;
						end else begin
							pc_q    <= pc_q + 6'd1;
							state_q <= ST_RUN;
						end
					end
				end
				ST_MIX: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

`ifndef SYNTHESIS
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.mul_busy && sts.div_busy))
		else $error("Multiplier and divider busy at the same time.");

	a_take_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |-> units_idle)
		else $error("Item taken while an arithmetic unit is busy.");

	a_mix_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MIX) |-> sts.out_free)
		else $error("Result written while the previous result is still held.");

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_RUN && pc_q == 6'd0))
		else $error("Sequence did not start at the first step after an item was taken.");
`endif
endmodule

[rtl/cascaded_attitude_pid_mixer.sv]
// Top level of the cascaded attitude PID controller with X-form motor mixer.
//
// Channel   Handshake                Payload
// input     in_valid / in_ready      throttle_pwm, targets, angles, rates, period_us
// output    out_valid / out_ready    motor_front_a/b, motor_rear_a/b, cut_off
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each item makes five passes through the shared radix-4 divider and fourteen
// multiplies, with the sequencing steps between them, before its result is registered.
// Reset restores the register defaults and clears the integrators and stored errors.
// A result waits in the output register; a new item is taken meanwhile, and its
// result is held back only if the previous one has not yet been taken.
module cascaded_attitude_pid_mixer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [10:0]        throttle_pwm,
	input  logic signed [31:0] target_roll,
	input  logic signed [31:0] target_pitch,
	input  logic signed [31:0] target_yaw_rate,
	input  logic signed [31:0] measured_roll,
	input  logic signed [31:0] measured_pitch,
	input  logic signed [31:0] rate_roll_axis,
	input  logic signed [31:0] rate_pitch_axis,
	input  logic signed [31:0] rate_yaw_axis,
	input  logic [15:0]        period_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [11:0]        motor_front_a,
	output logic [11:0]        motor_front_b,
	output logic [11:0]        motor_rear_a,
	output logic [11:0]        motor_rear_b,
	output logic               cut_off,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data
);
	import capm_pkg::*;

	capm_cmd_t cmd;
	capm_sts_t sts;
	logic      in_take;

	assign cfg_ready = 1'b1;
	assign in_take   = in_valid && in_ready;

	capm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_take  (in_take),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	capm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.load            (in_take),
		.throttle_pwm    (throttle_pwm),
		.target_roll     (target_roll),
		.target_pitch    (target_pitch),
		.target_yaw_rate (target_yaw_rate),
		.measured_roll   (measured_roll),
		.measured_pitch  (measured_pitch),
		.rate_roll_axis  (rate_roll_axis),
		.rate_pitch_axis (rate_pitch_axis),
		.rate_yaw_axis   (rate_yaw_axis),
		.period_us       (period_us),
		.cfg_we          (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.motor_front_a   (motor_front_a),
		.motor_front_b   (motor_front_b),
		.motor_rear_a    (motor_rear_a),
		.motor_rear_b    (motor_rear_b),
		.cut_off         (cut_off)
	);
endmodule
